/* hw/rtl/mntt_pkg.sv */
package mntt_pkg;

  // coefficient and modulus widths
  localparam int unsigned CoefW = 52;
  localparam int unsigned ModW = 50;
  localparam int unsigned HalfW = 26;

  // register stages inside one shoup multiplier
  localparam int unsigned ShoupLat = 7;

  // configuration port
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INV_N = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INV_N_QUOT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INV_N_ROOT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INV_N_ROOT_QUOT = 3'd4;

  localparam logic [ModW-1:0] ModulusRst = 50'd2;

  typedef enum logic [1:0] {
    ACT_FWD       = 2'd0,
    ACT_INV       = 2'd1,
    ACT_INV_FINAL = 2'd2,
    ACT_REDUCE    = 2'd3
  } action_e;

endpackage

/* hw/rtl/mntt_shoup_mul.sv */
// shoup product (w*x - hi52(wq*x)*q) mod 2^52, built from 26-bit partial products
module mntt_shoup_mul (
  input  logic                           clk_i,
  input  logic [mntt_pkg::CoefW-1:0]     x_i,
  input  logic [mntt_pkg::ModW-1:0]      w_i,
  input  logic [mntt_pkg::CoefW-1:0]     wq_i,
  input  logic [mntt_pkg::CoefW-1:0]     negq_i,
  output logic [mntt_pkg::CoefW-1:0]     res_o
);

  localparam int unsigned W = mntt_pkg::CoefW;
  localparam int unsigned H = mntt_pkg::HalfW;
  localparam int unsigned WHiW = mntt_pkg::ModW - H;

  logic [H-1:0]    x_lo, x_hi, wq_lo, wq_hi, w_lo;
  logic [WHiW-1:0] w_hi;

  // stage 1: partial products
  logic [W-1:0] pp00_q, pp01_q, pp10_q, pp11_q, pw00_q;
  logic [H-1:0] pw01_q, pw10_q;
  // stage 2: middle sums
  logic [W:0]   mid_q;
  logic [W-1:0] pp00_2_q, pp11_2_q, pw00_2_q;
  logic [H-1:0] pmid_q;
  // stage 3: low half carry and high partial
  logic [W:0]   low_q;
  logic [W-1:0] hs_q, plo_3_q;
  // stage 4: high half of wq*x
  logic [W-1:0] hi_q, plo_4_q;
  // stage 5: products with -q
  logic [W-1:0] hn00_q, plo_5_q;
  logic [H-1:0] hn01_q, hn10_q;
  // stage 6 and 7: final sum
  logic [H-1:0] cross_q;
  logic [W-1:0] tmp_q, res_q;

  assign x_lo  = x_i[H-1:0];
  assign x_hi  = x_i[W-1:H];
  assign wq_lo = wq_i[H-1:0];
  assign wq_hi = wq_i[W-1:H];
  assign w_lo  = w_i[H-1:0];
  assign w_hi  = w_i[mntt_pkg::ModW-1:H];

  always_ff @(posedge clk_i) begin
    pp00_q <= W'(x_lo) * W'(wq_lo);
    pp01_q <= W'(x_lo) * W'(wq_hi);
    pp10_q <= W'(x_hi) * W'(wq_lo);
    pp11_q <= W'(x_hi) * W'(wq_hi);
    pw00_q <= W'(x_lo) * W'(w_lo);
    pw01_q <= x_lo * H'(w_hi);
    pw10_q <= x_hi * w_lo;

    mid_q    <= {1'b0, pp01_q} + {1'b0, pp10_q};
    pp00_2_q <= pp00_q;
    pp11_2_q <= pp11_q;
    pw00_2_q <= pw00_q;
    pmid_q   <= pw01_q + pw10_q;

    low_q   <= {1'b0, pp00_2_q} + {1'b0, mid_q[H-1:0], H'(0)};
    hs_q    <= pp11_2_q + W'(mid_q[W:H]);
    plo_3_q <= pw00_2_q + {pmid_q, H'(0)};

    hi_q    <= hs_q + W'(low_q[W]);
    plo_4_q <= plo_3_q;

    hn00_q  <= W'(hi_q[H-1:0]) * W'(negq_i[H-1:0]);
    hn01_q  <= hi_q[H-1:0] * negq_i[W-1:H];
    hn10_q  <= hi_q[W-1:H] * negq_i[H-1:0];
    plo_5_q <= plo_4_q;

    cross_q <= hn01_q + hn10_q;
    tmp_q   <= hn00_q + plo_5_q;

    res_q <= tmp_q + {cross_q, H'(0)};
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/modular_ntt_butterfly.sv */
// modular ntt butterfly with lazy reduction and shoup twiddle products, q below 2^50.
// one item is taken on every cycle in which start_i is high; busy_o is never raised,
// since the pipeline has no stall point. each item gives one result pair, shown on
// out_a_o/out_b_o for exactly one cycle with valid_o, in order. the receiver cannot hold
// results off, so it must take every strobe.
// the latency is set by two operand stages, the seven stages of the
// shoup multiplier (four 26x26 partial products for hi52(wq*x), then three for the
// low half of hi*(-q)) and one output stage. both multipliers run on every item:
// lane a serves only the scaled final inverse step, lane b the twiddle of the forward
// and inverse steps and the scaled root of the final inverse step.
// action 0 forward ct step, 1 inverse gs step, 2 final inverse scaled by inv_n,
// 3 full reduction. configuration writes land at once and are meant for idle time.
module modular_ntt_butterfly (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       action_i,
  input  logic [mntt_pkg::CoefW-1:0]       coef_a_i,
  input  logic [mntt_pkg::CoefW-1:0]       coef_b_i,
  input  logic [mntt_pkg::ModW-1:0]        root_i,
  input  logic [mntt_pkg::CoefW-1:0]       root_quot_i,
  input  logic                             cfg_we_i,
  input  logic [mntt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mntt_pkg::CoefW-1:0]       cfg_wdata_i,
  output logic                             valid_o,
  output logic [mntt_pkg::CoefW-1:0]       out_a_o,
  output logic [mntt_pkg::CoefW-1:0]       out_b_o
);

  localparam int unsigned W = mntt_pkg::CoefW;
  localparam int unsigned MW = mntt_pkg::ModW;
  localparam int unsigned Lat = mntt_pkg::ShoupLat;
  localparam int unsigned LatCycles = Lat + 3;

  typedef struct packed {
    mntt_pkg::action_e act;
    logic [W-1:0]      v0;
    logic [W-1:0]      v1;
  } side_t;

  // configuration registers
  logic [MW-1:0] modulus_q, inv_n_q, inv_n_root_q;
  logic [W-1:0]  inv_n_quot_q, inv_n_root_quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q         <= mntt_pkg::ModulusRst;
      inv_n_q           <= '0;
      inv_n_quot_q      <= '0;
      inv_n_root_q      <= '0;
      inv_n_root_quot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mntt_pkg::CFG_MODULUS:         modulus_q <= cfg_wdata_i[MW-1:0];
        mntt_pkg::CFG_INV_N:           inv_n_q <= cfg_wdata_i[MW-1:0];
        mntt_pkg::CFG_INV_N_QUOT:      inv_n_quot_q <= cfg_wdata_i;
        mntt_pkg::CFG_INV_N_ROOT:      inv_n_root_q <= cfg_wdata_i[MW-1:0];
        mntt_pkg::CFG_INV_N_ROOT_QUOT: inv_n_root_quot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [MW:0]  q2;     // 2q
  logic [W-1:0] q2_w;   // 2q at coefficient width
  logic [W-1:0] negq;   // -q mod 2^52

  assign q2   = {modulus_q, 1'b0};
  assign q2_w = W'(q2);
  assign negq = W'(0) - W'(modulus_q);

  // no stall point anywhere, an item enters on every start
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // stage 1: conditional -2q on a and b, a+b, a-b+2q, twiddle operand pick
  // ---------------------------------------------------------------------------
  mntt_pkg::action_e act_in;
  logic [W:0]   a_m, b_m, sum_d;
  logic [W-1:0] a1_d, b1_d, dif_d, xb1_d;

  assign act_in = mntt_pkg::action_e'(action_i);
  assign a_m    = {1'b0, coef_a_i} - {2'b0, q2};
  assign b_m    = {1'b0, coef_b_i} - {2'b0, q2};
  assign a1_d   = a_m[W] ? coef_a_i : a_m[W-1:0];
  assign b1_d   = b_m[W] ? coef_b_i : b_m[W-1:0];
  assign sum_d  = {1'b0, coef_a_i} + {1'b0, coef_b_i};
  assign dif_d  = coef_a_i - coef_b_i + q2_w;

  always_comb begin
    case (act_in) inside
      mntt_pkg::ACT_FWD:                        xb1_d = coef_b_i;
      mntt_pkg::ACT_REDUCE:                     xb1_d = b1_d;
      mntt_pkg::ACT_INV, mntt_pkg::ACT_INV_FINAL: xb1_d = dif_d;
    endcase
  end

  logic              p1_vld_q;
  mntt_pkg::action_e p1_act_q;
  logic [W:0]        p1_sum_q;
  logic [W-1:0]      p1_a1_q, p1_xb_q, p1_rootq_q;
  logic [MW-1:0]     p1_root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_act_q   <= act_in;
    p1_sum_q   <= sum_d;
    p1_a1_q    <= a1_d;
    p1_xb_q    <= xb1_d;
    p1_root_q  <= root_i;
    p1_rootq_q <= root_quot_i;
  end

  // ---------------------------------------------------------------------------
  // stage 2: reduce a+b once, a1+2q, multiplier operands
  // ---------------------------------------------------------------------------
  logic [W+1:0] s_m;
  logic [W-1:0] s1, a1q2;
  side_t        side_d;

  assign s_m  = {1'b0, p1_sum_q} - {3'b0, q2};
  assign s1   = s_m[W+1] ? p1_sum_q[W-1:0] : s_m[W-1:0];
  assign a1q2 = p1_a1_q + q2_w;

  always_comb begin
    side_d.act = p1_act_q;
    side_d.v0  = (p1_act_q == mntt_pkg::ACT_INV) ? s1 : p1_a1_q;
    side_d.v1  = (p1_act_q == mntt_pkg::ACT_FWD) ? a1q2 : p1_xb_q;
  end

  logic          p2_vld_q;
  side_t         p2_side_q;
  logic [W-1:0]  xa_q, xb_q, wqb_q;
  logic [MW-1:0] wb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_side_q <= side_d;
    xa_q      <= s1;
    xb_q      <= p1_xb_q;
    // the final inverse step uses the scaled constant on lane b
    if (p1_act_q == mntt_pkg::ACT_INV_FINAL) begin
      wb_q  <= inv_n_root_q;
      wqb_q <= inv_n_root_quot_q;
    end else begin
      wb_q  <= p1_root_q;
      wqb_q <= p1_rootq_q;
    end
  end

  // ---------------------------------------------------------------------------
  // shoup multipliers and the side line that keeps pace with them
  // ---------------------------------------------------------------------------
  logic [W-1:0] ta, tb;

  mntt_shoup_mul u_shoup_a (
    .clk_i  (clk_i),
    .x_i    (xa_q),
    .w_i    (inv_n_q),
    .wq_i   (inv_n_quot_q),
    .negq_i (negq),
    .res_o  (ta)
  );

  mntt_shoup_mul u_shoup_b (
    .clk_i  (clk_i),
    .x_i    (xb_q),
    .w_i    (wb_q),
    .wq_i   (wqb_q),
    .negq_i (negq),
    .res_o  (tb)
  );

  side_t side_q [Lat];
  logic  side_vld_q [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        side_vld_q[i] <= 1'b0;
      end
    end else begin
      side_vld_q[0] <= p2_vld_q;
      for (int i = 1; i < Lat; i++) begin
        side_vld_q[i] <= side_vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= p2_side_q;
    for (int i = 1; i < Lat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: forward butterfly sums, inverse step pass-through or a final subtract of q
  // ---------------------------------------------------------------------------
  side_t        sd;
  logic [W-1:0] red_a_in, red_b_in, red_a, red_b, ra_d, rb_d;
  logic [W:0]   ra_m, rb_m;

  assign sd       = side_q[Lat-1];
  assign red_a_in = (sd.act == mntt_pkg::ACT_REDUCE) ? sd.v0 : ta;
  assign red_b_in = (sd.act == mntt_pkg::ACT_REDUCE) ? sd.v1 : tb;
  assign ra_m     = {1'b0, red_a_in} - {3'b0, modulus_q};
  assign rb_m     = {1'b0, red_b_in} - {3'b0, modulus_q};
  assign red_a    = ra_m[W] ? red_a_in : ra_m[W-1:0];
  assign red_b    = rb_m[W] ? red_b_in : rb_m[W-1:0];

  always_comb begin
    case (sd.act) inside
      mntt_pkg::ACT_FWD: begin
        ra_d = sd.v0 + tb;
        rb_d = sd.v1 - tb;
      end
      mntt_pkg::ACT_INV: begin
        ra_d = sd.v0;
        rb_d = tb;
      end
      mntt_pkg::ACT_INV_FINAL, mntt_pkg::ACT_REDUCE: begin
        ra_d = red_a;
        rb_d = red_b;
      end
    endcase
  end

  logic         valid_q;
  logic [W-1:0] out_a_q, out_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_a_q <= ra_d;
    out_b_q <= rb_d;
  end

  assign valid_o = valid_q;
  assign out_a_o = out_a_q;
  assign out_b_o = out_b_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LatCycles valid_o)
    else $error("accepted item did not produce a result");

  // no result without an item accepted the fixed latency before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LatCycles))
    else $error("result without an accepted item");

  // the side line takes every item that leaves stage 2
  a_side_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |=> side_vld_q[0])
    else $error("side line lost an item");

endmodule
